[src/qmn_pkg.sv]
// Shared widths, types and a helper function for the quaternion multiply/normalize core.
`default_nettype none

package qmn_pkg;

	// Component format and configuration width.
	localparam int COMP_W    = 16;
	localparam int FRAC_BITS = 13;
	localparam int TOL_W     = 27;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(67109);

	// Internal widths derived from the component format.
	localparam int PROD_W   = 2 * COMP_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int P_W      = SUM_W - FRAC_BITS;
	localparam int SQ_W     = 2 * P_W;
	localparam int RT_STEPS = SQ_W / 2;
	localparam int LEN_W    = RT_STEPS;
	localparam int Q_W      = FRAC_BITS + 1;
	localparam int D_W      = LEN_W + 1;
	localparam int R_W      = D_W + Q_W;

	// Stage count: products, sums, squares, length test, root, divide setup, divide.
	localparam int NST = 4 + RT_STEPS + 1 + Q_W;

	// Saturation limits of a component, held at the product width.
	localparam logic signed [P_W-1:0] COMP_HI = P_W'((2 ** (COMP_W - 1)) - 1);
	localparam logic signed [P_W-1:0] COMP_LO = P_W'(-(2 ** (COMP_W - 1)));

	typedef logic signed [COMP_W-1:0] comp_t;

	// Product and flags that ride along the back half of the pipeline.
	typedef struct packed {
		logic [3:0][P_W-1:0] p;
		logic                zero;
		logic                renorm;
	} qmn_tag_t;

	// One finished result word.
	typedef struct packed {
		logic [3:0][COMP_W-1:0] r;
		logic                   renorm;
		logic                   zero;
	} qmn_res_t;

	// Clamp a product-width value to the signed component range.
	function automatic comp_t sat_comp(input logic signed [P_W-1:0] x);
		comp_t y;
		if (x > COMP_HI) begin
			y = COMP_HI[COMP_W-1:0];
		end else if (x < COMP_LO) begin
			y = COMP_LO[COMP_W-1:0];
		end else begin
			y = x[COMP_W-1:0];
		end
		return y;
	endfunction

endpackage

`default_nettype wire

[src/qmn_if.sv]
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface qmn_in_if;
	logic          valid;
	logic          ready;
	qmn_pkg::comp_t a_x;
	qmn_pkg::comp_t a_y;
	qmn_pkg::comp_t a_z;
	qmn_pkg::comp_t a_w;
	qmn_pkg::comp_t b_x;
	qmn_pkg::comp_t b_y;
	qmn_pkg::comp_t b_z;
	qmn_pkg::comp_t b_w;

	modport source(output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
	modport sink(input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
endinterface

interface qmn_out_if;
	logic          valid;
	logic          ready;
	qmn_pkg::comp_t r_x;
	qmn_pkg::comp_t r_y;
	qmn_pkg::comp_t r_z;
	qmn_pkg::comp_t r_w;
	logic          renormalized;
	logic          zero_length;

	modport source(output valid, r_x, r_y, r_z, r_w, renormalized, zero_length, input ready);
	modport sink(input valid, r_x, r_y, r_z, r_w, renormalized, zero_length, output ready);
endinterface

`default_nettype wire

[src/quaternion_multiply_normalize_core.sv]
// Top level: pipelined quaternion Hamilton product with conditional renormalization.
`default_nettype none

// The core takes one input word per clock while ready is high and returns one result
// word per input word, in order. The pipeline has 40 register stages followed by an
// output register: one stage of sixteen products, one of rounded sums, one of squares,
// one for the squared length and its tolerance test, 21 stages of a one-bit-per-stage
// square root, a divide setup stage and 14 stages of a one-bit-per-stage restoring
// divider run in lockstep by the four components on a shared divisor. A two-word
// output buffer lets the core keep accepting while a result waits; ready drops
// only when both buffer words are full. The tolerance register may be written at any
// time the core is idle; it is read by the length test stage.
module quaternion_multiply_normalize_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [qmn_pkg::TOL_W-1:0] cfg_wdata,
	qmn_in_if.sink                        din,
	qmn_out_if.source                     dout
);

	localparam int NST      = qmn_pkg::NST;
	localparam int P_W      = qmn_pkg::P_W;
	localparam int SQ_W     = qmn_pkg::SQ_W;
	localparam int SUM_W    = qmn_pkg::SUM_W;
	localparam int PROD_W   = qmn_pkg::PROD_W;
	localparam int RT_STEPS = qmn_pkg::RT_STEPS;
	localparam int Q_W      = qmn_pkg::Q_W;
	localparam int R_W      = qmn_pkg::R_W;
	localparam int D_W      = qmn_pkg::D_W;
	localparam int LEN_W    = qmn_pkg::LEN_W;
	localparam int FB       = qmn_pkg::FRAC_BITS;

	// Terms that are subtracted in the Hamilton product, bit 4*lane+term.
	localparam logic [15:0] NEG_TERM = 16'hE428;
	localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FB - 1);
	localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FB);

	// Tolerance register.
	logic [qmn_pkg::TOL_W-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= qmn_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Global advance: every stage moves while the output buffer has room.
	logic            skid_vld_q;
	logic            out_vld_q;
	logic            en;
	logic [NST-1:0]  vld_q;

	assign en        = !skid_vld_q;
	assign din.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], din.valid};
		end
	end

	// Stage 1: the sixteen partial products.
	logic signed [PROD_W-1:0] prod_s1 [16];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0]  <= din.a_w * din.b_x;
			prod_s1[1]  <= din.a_x * din.b_w;
			prod_s1[2]  <= din.a_y * din.b_z;
			prod_s1[3]  <= din.a_z * din.b_y;
			prod_s1[4]  <= din.a_w * din.b_y;
			prod_s1[5]  <= din.a_x * din.b_z;
			prod_s1[6]  <= din.a_y * din.b_w;
			prod_s1[7]  <= din.a_z * din.b_x;
			prod_s1[8]  <= din.a_w * din.b_z;
			prod_s1[9]  <= din.a_x * din.b_y;
			prod_s1[10] <= din.a_y * din.b_x;
			prod_s1[11] <= din.a_z * din.b_w;
			prod_s1[12] <= din.a_w * din.b_w;
			prod_s1[13] <= din.a_x * din.b_x;
			prod_s1[14] <= din.a_y * din.b_y;
			prod_s1[15] <= din.a_z * din.b_z;
		end
	end

	// Stage 2: signed sums, rounded half up to the component fraction.
	logic [3:0][P_W-1:0] p_d2;
	logic [3:0][P_W-1:0] p_s2;

	always_comb begin
		logic signed [SUM_W-1:0] acc;
		for (int i = 0; i < 4; i++) begin
			acc = HALF_LSB;
			for (int j = 0; j < 4; j++) begin
				if (NEG_TERM[4*i+j]) begin
					acc = acc - SUM_W'(prod_s1[4*i+j]);
				end else begin
					acc = acc + SUM_W'(prod_s1[4*i+j]);
				end
			end
			p_d2[i] = acc[SUM_W-1:FB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= p_d2;
		end
	end

	// Stage 3: squares of the four components.
	logic [SQ_W-1:0]     sqp_s3 [4];
	logic [3:0][P_W-1:0] p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sqp_s3[i] <= SQ_W'($signed(p_s2[i]) * $signed(p_s2[i]));
			end
			p_s3 <= p_s2;
		end
	end

	// Stage 4: squared length, zero test and tolerance test.
	logic [SQ_W-1:0]   sq_d4;
	logic [SQ_W-1:0]   diff_d4;
	logic [SQ_W-1:0]   sq_s4;
	qmn_pkg::qmn_tag_t tag_s4;

	always_comb begin
		sq_d4   = sqp_s3[0] + sqp_s3[1] + sqp_s3[2] + sqp_s3[3];
		diff_d4 = (sq_d4 > ONE_SQ) ? (sq_d4 - ONE_SQ) : (ONE_SQ - sq_d4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4         <= sq_d4;
			tag_s4.p      <= p_s3;
			tag_s4.zero   <= (sq_d4 == '0);
			tag_s4.renorm <= (sq_d4 != '0) && (diff_d4 > SQ_W'(tol_q));
		end
	end

	// Square root, one result bit per stage.
	logic [SQ_W-1:0]   rt_v_s   [RT_STEPS];
	logic [SQ_W-1:0]   rt_r_s   [RT_STEPS];
	qmn_pkg::qmn_tag_t rt_tag_s [RT_STEPS];

	for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
		localparam logic [SQ_W-1:0] BIT_V = SQ_W'(1) << (2 * (RT_STEPS - 1 - k));
		logic [SQ_W-1:0]   v_in;
		logic [SQ_W-1:0]   r_in;
		logic [SQ_W-1:0]   trial;
		qmn_pkg::qmn_tag_t tag_in;

		if (k == 0) begin : g_first
			assign v_in   = sq_s4;
			assign r_in   = '0;
			assign tag_in = tag_s4;
		end else begin : g_next
			assign v_in   = rt_v_s[k-1];
			assign r_in   = rt_r_s[k-1];
			assign tag_in = rt_tag_s[k-1];
		end

		assign trial = r_in + BIT_V;

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					rt_v_s[k] <= v_in - trial;
					rt_r_s[k] <= (r_in >> 1) + BIT_V;
				end else begin
					rt_v_s[k] <= v_in;
					rt_r_s[k] <= r_in >> 1;
				end
				rt_tag_s[k] <= tag_in;
			end
		end
	end

	// Divide setup: magnitudes, rounding numerators and the doubled length.
	logic [LEN_W-1:0]  len_w;
	logic [R_W-1:0]    dp_n_s  [4];
	logic [3:0]        dp_neg_s;
	logic [D_W-1:0]    dp_d_s;
	qmn_pkg::qmn_tag_t dp_tag_s;

	assign len_w = rt_r_s[RT_STEPS-1][LEN_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				logic [P_W-1:0] pv;
				logic [P_W-1:0] mag;
				pv  = rt_tag_s[RT_STEPS-1].p[i];
				mag = pv[P_W-1] ? -pv : pv;
				dp_n_s[i]   <= (R_W'(mag) << Q_W) + R_W'(len_w);
				dp_neg_s[i] <= pv[P_W-1];
			end
			dp_d_s   <= {len_w, 1'b0};
			dp_tag_s <= rt_tag_s[RT_STEPS-1];
		end
	end

	// Restoring divider, one quotient bit per stage for all four components.
	logic [R_W-1:0]    dv_r_s   [Q_W][4];
	logic [Q_W-1:0]    dv_q_s   [Q_W][4];
	logic [3:0]        dv_neg_s [Q_W];
	logic [D_W-1:0]    dv_d_s   [Q_W];
	qmn_pkg::qmn_tag_t dv_tag_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_dv
		logic [R_W-1:0]    r_in [4];
		logic [Q_W-1:0]    q_in [4];
		logic [3:0]        neg_in;
		logic [D_W-1:0]    d_in;
		logic [R_W-1:0]    d_sh;
		qmn_pkg::qmn_tag_t tag_in;

		if (j == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 4; i++) begin
					r_in[i] = dp_n_s[i];
					q_in[i] = '0;
				end
			end
			assign neg_in = dp_neg_s;
			assign d_in   = dp_d_s;
			assign tag_in = dp_tag_s;
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 4; i++) begin
					r_in[i] = dv_r_s[j-1][i];
					q_in[i] = dv_q_s[j-1][i];
				end
			end
			assign neg_in = dv_neg_s[j-1];
			assign d_in   = dv_d_s[j-1];
			assign tag_in = dv_tag_s[j-1];
		end

		assign d_sh = R_W'(d_in) << (Q_W - 1 - j);

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					if (r_in[i] >= d_sh) begin
						dv_r_s[j][i] <= r_in[i] - d_sh;
						dv_q_s[j][i] <= {q_in[i][Q_W-2:0], 1'b1};
					end else begin
						dv_r_s[j][i] <= r_in[i];
						dv_q_s[j][i] <= {q_in[i][Q_W-2:0], 1'b0};
					end
				end
				dv_neg_s[j] <= neg_in;
				dv_d_s[j]   <= d_in;
				dv_tag_s[j] <= tag_in;
			end
		end
	end

	// Result selection: zero, the scaled quotient or the product, the last two saturated to a component.
	qmn_pkg::qmn_res_t res_d;
	logic              push;

	always_comb begin
		logic signed [P_W-1:0] qv;
		res_d.renorm = dv_tag_s[Q_W-1].renorm;
		res_d.zero   = dv_tag_s[Q_W-1].zero;
		for (int i = 0; i < 4; i++) begin
			qv = $signed(P_W'(dv_q_s[Q_W-1][i]));
			if (dv_tag_s[Q_W-1].zero) begin
				res_d.r[i] = '0;
			end else if (dv_tag_s[Q_W-1].renorm) begin
				res_d.r[i] = qmn_pkg::sat_comp(dv_neg_s[Q_W-1][i] ? -qv : qv);
			end else begin
				res_d.r[i] = qmn_pkg::sat_comp($signed(dv_tag_s[Q_W-1].p[i]));
			end
		end
	end

	assign push = en && vld_q[NST-1];

	// Output register with a skid word behind it.
	qmn_pkg::qmn_res_t out_q;
	qmn_pkg::qmn_res_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || dout.ready) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || dout.ready) begin
			out_q <= skid_vld_q ? skid_q : res_d;
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign dout.valid        = out_vld_q;
	assign dout.r_x          = out_q.r[0];
	assign dout.r_y          = out_q.r[1];
	assign dout.r_z          = out_q.r[2];
	assign dout.r_w          = out_q.r[3];
	assign dout.renormalized = out_q.renorm;
	assign dout.zero_length  = out_q.zero;

`ifndef NO_ASSERTIONS
	// The skid word fills only behind a held output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word valid without output word");

	// While the skid word is full the pipeline does not move.
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> vld_q == $past(vld_q))
		else $error("pipeline advanced while output buffer full");

	// A zero-length result is never flagged as renormalized.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_q.renorm && out_q.zero))
		else $error("renormalized and zero_length both set");

	// A zero-length result carries all-zero components.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.zero) |-> (out_q.r == '0))
		else $error("zero_length result with nonzero components");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the quaternion multiply/normalize core.
`default_nettype none

module tb_top;

	// One input word: both quaternions as signed components.
	typedef struct {
		qmn_pkg::comp_t ax, ay, az, aw, bx, by, bz, bw;
	} quat_pair_t;

	// One expected result word.
	typedef struct {
		qmn_pkg::comp_t rx, ry, rz, rw;
		logic  renorm;
		logic  zero;
	} quat_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [qmn_pkg::TOL_W-1:0] cfg_wdata = '0;

	qmn_in_if  din();
	qmn_out_if dout();

	quaternion_multiply_normalize_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.din(din),
		.dout(dout)
	);

	quat_pair_t pending_pairs[$];
	quat_res_t  expected_products[$];
	logic [qmn_pkg::TOL_W-1:0] tolerance;
	int mismatch_count = 0;
	int hold_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit sender_paused = 1'b0;
	bit long_hold_req = 1'b0;

	// Clock generation.
	always #5 clk = ~clk;

	// Integer square root, floor.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	// Round a product sum to the component fraction, half up.
	function automatic longint round_half_up(input longint s);
		return (s + (64'sd1 <<< (qmn_pkg::FRAC_BITS - 1))) >>> qmn_pkg::FRAC_BITS;
	endfunction

	function automatic qmn_pkg::comp_t clamp_comp(input longint x);
		longint hi;
		hi = (64'sd1 <<< (qmn_pkg::COMP_W - 1)) - 1;
		if (x > hi) return qmn_pkg::comp_t'(hi);
		if (x < -hi - 1) return qmn_pkg::comp_t'(-hi - 1);
		return qmn_pkg::comp_t'(x);
	endfunction

	// Divide a component by the length, nearest with ties away from zero.
	function automatic longint scale_by_length(input longint p, input longint unsigned len);
		longint unsigned mag, q;
		mag = (p < 0) ? longint'(-p) : p;
		q = ((mag << (qmn_pkg::FRAC_BITS + 1)) + len) / (2 * len);
		return (p < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Hamilton product with conditional renormalization.
	function automatic quat_res_t hamilton_normalize(input quat_pair_t q,
			input logic [qmn_pkg::TOL_W-1:0] tol);
		longint ax, ay, az, aw, bx, by, bz, bw;
		longint p[4];
		longint unsigned sq, one, diff, len;
		quat_res_t r;
		ax = q.ax; ay = q.ay; az = q.az; aw = q.aw;
		bx = q.bx; by = q.by; bz = q.bz; bw = q.bw;
		p[0] = round_half_up(aw*bx + ax*bw + ay*bz - az*by);
		p[1] = round_half_up(aw*by - ax*bz + ay*bw + az*bx);
		p[2] = round_half_up(aw*bz + ax*by - ay*bx + az*bw);
		p[3] = round_half_up(aw*bw - ax*bx - ay*by - az*bz);
		sq = 0;
		for (int i = 0; i < 4; i++) sq += longint'(p[i] * p[i]);
		one = 64'd1 << (2 * qmn_pkg::FRAC_BITS);
		diff = (sq > one) ? sq - one : one - sq;
		r.zero = (sq == 0);
		r.renorm = 1'b0;
		if (r.zero) begin
			for (int i = 0; i < 4; i++) p[i] = 0;
		end else if (diff > tol) begin
			len = int_sqrt(sq);
			r.renorm = 1'b1;
			for (int i = 0; i < 4; i++) p[i] = scale_by_length(p[i], len);
		end
		r.rx = clamp_comp(p[0]);
		r.ry = clamp_comp(p[1]);
		r.rz = clamp_comp(p[2]);
		r.rw = clamp_comp(p[3]);
		return r;
	endfunction

	function automatic qmn_pkg::comp_t rand_comp();
		case ($urandom_range(0, 5))
			0: return qmn_pkg::comp_t'(16'sh7fff);
			1: return qmn_pkg::comp_t'(16'sh8000);
			2: return qmn_pkg::comp_t'($urandom_range(0, 16383) - 8192);
			default: return qmn_pkg::comp_t'($urandom);
		endcase
	endfunction

	// Near-unit quaternion component: magnitude up to about one half.
	function automatic qmn_pkg::comp_t unit_comp();
		return qmn_pkg::comp_t'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	function automatic quat_pair_t make_pair(input int mode);
		quat_pair_t q;
		if (mode == 0) begin
			q.ax = rand_comp(); q.ay = rand_comp(); q.az = rand_comp(); q.aw = rand_comp();
			q.bx = rand_comp(); q.by = rand_comp(); q.bz = rand_comp(); q.bw = rand_comp();
		end else begin
			q.ax = unit_comp(); q.ay = unit_comp(); q.az = unit_comp(); q.aw = unit_comp();
			q.bx = unit_comp(); q.by = unit_comp(); q.bz = unit_comp(); q.bw = unit_comp();
		end
		return q;
	endfunction

	function automatic quat_pair_t pair_of(input qmn_pkg::comp_t a, input qmn_pkg::comp_t b);
		quat_pair_t q;
		q.ax = a; q.ay = a; q.az = a; q.aw = a;
		q.bx = b; q.by = b; q.bz = b; q.bw = b;
		return q;
	endfunction

	function automatic quat_pair_t axis_pair(input qmn_pkg::comp_t aw,
			input qmn_pkg::comp_t bw, input qmn_pkg::comp_t bx);
		quat_pair_t q;
		q = pair_of(16'sd0, 16'sd0);
		q.aw = aw; q.bw = bw; q.bx = bx;
		return q;
	endfunction

	task automatic wait_drained();
		while (pending_pairs.size() != 0 || expected_products.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [qmn_pkg::TOL_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tolerance = v;
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++)
			pending_pairs.push_back(make_pair(($urandom_range(0, 9) < 7) ? 1 : 0));
	endtask

	// Sender: offers the oldest queued word with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 1'b0;
			din.a_x <= '0; din.a_y <= '0; din.a_z <= '0; din.a_w <= '0;
			din.b_x <= '0; din.b_y <= '0; din.b_z <= '0; din.b_w <= '0;
			send_gap <= 0;
		end else begin
			if (din.valid && din.ready) begin
				expected_products.push_back(hamilton_normalize(pending_pairs.pop_front(),
					tolerance));
			end
			if (!din.valid || din.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					din.valid <= 1'b0;
				end else if (pending_pairs.size() > 0 && !sender_paused) begin
					din.valid <= 1'b1;
					din.a_x <= pending_pairs[0].ax; din.a_y <= pending_pairs[0].ay;
					din.a_z <= pending_pairs[0].az; din.a_w <= pending_pairs[0].aw;
					din.b_x <= pending_pairs[0].bx; din.b_y <= pending_pairs[0].by;
					din.b_z <= pending_pairs[0].bz; din.b_w <= pending_pairs[0].bw;
					if ($urandom_range(0, 3) == 0)
						send_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
							: $urandom_range(0, 2);
				end else begin
					din.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
			recv_gap <= 0;
			hold_cycles <= 0;
		end else if (long_hold_req && hold_cycles == 0) begin
			hold_cycles <= 150;
			dout.ready <= 1'b0;
		end else if (hold_cycles > 1) begin
			hold_cycles <= hold_cycles - 1;
		end else if (hold_cycles == 1) begin
			hold_cycles <= 0;
			dout.ready <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= 1'b1;
			if ($urandom_range(0, 4) == 0)
				recv_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
					: $urandom_range(0, 2);
		end
	end

	// Monitor: compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			if (expected_products.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result word: %0d %0d %0d %0d", dout.r_x, dout.r_y,
						dout.r_z, dout.r_w);
			end else begin
				automatic quat_res_t e = expected_products.pop_front();
				if (e.rx !== dout.r_x || e.ry !== dout.r_y || e.rz !== dout.r_z ||
						e.rw !== dout.r_w || e.renorm !== dout.renormalized ||
						e.zero !== dout.zero_length) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected %0d %0d %0d %0d r%b z%b, %s",
							e.rx, e.ry, e.rz, e.rw, e.renorm, e.zero,
							$sformatf("got %0d %0d %0d %0d r%b z%b", dout.r_x,
							dout.r_y, dout.r_z, dout.r_w, dout.renormalized,
							dout.zero_length));
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		tolerance = qmn_pkg::TOL_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset tolerance: extremes, zero, exact unit, near unit.
		pending_pairs.push_back(pair_of(16'sd0, 16'sd0));
		pending_pairs.push_back(axis_pair(16'sd8192, 16'sd8192, 16'sd0));
		pending_pairs.push_back(axis_pair(16'sd8192, 16'sd8196, 16'sd0));
		pending_pairs.push_back(axis_pair(16'sd8192, 16'sd8188, 16'sd0));
		pending_pairs.push_back(axis_pair(-16'sd8192, 16'sd8192, 16'sd0));
		pending_pairs.push_back(axis_pair(16'sd1, 16'sd1, 16'sd0));
		pending_pairs.push_back(axis_pair(16'sd0, 16'sd0, 16'sd1));
		pending_pairs.push_back(axis_pair(16'sd16384, 16'sd16384, 16'sd0));
		pending_pairs.push_back(pair_of(16'sh7fff, 16'sh7fff));
		pending_pairs.push_back(pair_of(16'sh8000, 16'sh8000));
		pending_pairs.push_back(pair_of(16'sh7fff, 16'sh8000));
		pending_pairs.push_back(pair_of(-16'sd1, -16'sd1));
		pending_pairs.push_back(pair_of(16'sd4096, 16'sd4096));
		pending_pairs.push_back(axis_pair(16'sd5793, 16'sd8192, 16'sd5793));
		pending_pairs.push_back(axis_pair(16'sd3, 16'sd2, 16'sd0));
		wait_drained();

		// Tolerance of one squared unit: zero length lies within tolerance and passes.
		write_tolerance(qmn_pkg::TOL_W'(67108864));
		pending_pairs.push_back(pair_of(16'sd0, 16'sd0));
		pending_pairs.push_back(axis_pair(16'sd1, 16'sd1, 16'sd0));
		pending_pairs.push_back(pair_of(16'sh7fff, 16'sh8000));
		random_phase(150);
		wait_drained();

		// Zero tolerance: anything nonzero that is off exact unit length is renormalized.
		write_tolerance('0);
		pending_pairs.push_back(axis_pair(16'sd8192, 16'sd8192, 16'sd0));
		random_phase(200);
		// Long hold-off on the result side while words keep coming.
		long_hold_req = 1'b1;
		while (hold_cycles == 0) @(posedge clk);
		long_hold_req = 1'b0;
		wait_drained();

		// All-ones register pattern, the reset value, then random settings.
		write_tolerance({qmn_pkg::TOL_W{1'b1}});
		random_phase(150);
		wait_drained();
		write_tolerance(qmn_pkg::TOL_RESET);
		random_phase(200);
		// Sender pauses with words in flight until every expected word has come.
		repeat (50) @(posedge clk);
		sender_paused = 1'b1;
		while (expected_products.size() != 0) @(posedge clk);
		sender_paused = 1'b0;
		wait_drained();
		write_tolerance(qmn_pkg::TOL_W'($urandom_range(0, 2000000)));
		random_phase(170);
		wait_drained();
		write_tolerance(qmn_pkg::TOL_W'($urandom_range(0, 67108864)));
		random_phase(160);
		wait_drained();

		if (mismatch_count == 0 && expected_products.size() == 0) begin
			$display("quaternion_multiply_normalize_core test passed");
		end else begin
			$display("quaternion_multiply_normalize_core test failed");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#2000000;
		$display("quaternion_multiply_normalize_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
